// File: sv/mpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared constants and types of the message packet framer.
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int unsigned PACKET_BYTES_DEF = 200;
    localparam int unsigned HDR_BYTES        = 46;
    localparam int unsigned CMD_DEPTH        = 4;
    localparam int unsigned OUT_DEPTH        = 4;

    // one classified item, front part to back part
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic        pkt_last;
        logic [31:0] timestamp;
        logic [7:0]  packet_len;
        logic [15:0] sequence_num;
        logic [15:0] packet_total;
        logic [15:0] packet_id;
        logic [15:0] checksum;
    } t_cmd;

    // one framed result word
    typedef struct packed {
        logic [63:0] frame_word;
        logic [3:0]  byte_count;
        logic        packet_end;
        logic        last;
    } t_res;

endpackage

// File: sv/mpf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module mpf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = mpf_pkg::CMD_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             c_wr, c_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign c_wr      = i_wr_en && !o_full;
    assign c_rd      = i_rd_en && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (c_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (c_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (c_wr && !c_rd) begin
            n_count = r_count + 1'b1;
        end else if (c_rd && !c_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: sv/mpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_front
// Message and packet tracking: classifies each item and builds its command.
// ----------------------------------------------------------------------------
module mpf_front #(
    parameter int unsigned PACKET_BYTES = mpf_pkg::PACKET_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic [15:0]  i_message_length,
    input  logic [15:0]  i_packet_id,
    input  logic [31:0]  i_timestamp,
    output mpf_pkg::t_cmd o_cmd,
    output logic [63:0]  o_source_id
);

    import mpf_pkg::*;

    // packet total = ceil(len / PACKET_BYTES) by reciprocal multiply, exact for 17-bit input
    localparam int unsigned DIV_L  = $clog2(PACKET_BYTES);
    localparam int unsigned DIV_S  = 17 + DIV_L;
    localparam int unsigned DIV_M  = (2 ** DIV_S) / PACKET_BYTES + 1;
    localparam int unsigned PROD_W = 18 + DIV_S;

    localparam logic [DIV_S:0] C_RECIP = DIV_M[DIV_S:0];
    localparam logic [15:0]    C_PB16  = 16'(PACKET_BYTES);
    localparam logic [7:0]     C_PB8   = 8'(PACKET_BYTES);

    logic [63:0] r_source_id;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_packet_pos, n_packet_pos;
    logic [15:0] r_sequence, n_sequence;
    logic [15:0] r_packet_total, n_packet_total;
    logic [7:0]  r_packet_len, n_packet_len;
    logic [15:0] r_id_latch, n_id_latch;
    logic [15:0] r_data_sum, n_data_sum;

    logic              c_first_msg, c_first_pkt, c_pkt_last;
    logic [15:0]       c_mlen;
    logic [16:0]       c_div_in;
    logic [PROD_W-1:0] c_div_prod;
    logic [7:0]        c_pos, c_pos_inc;
    logic [15:0]       c_seq;

    always_comb begin
        c_first_msg = (r_bytes_left == 16'd0);
        c_mlen      = (i_message_length == 16'd0) ? 16'd1 : i_message_length;
        c_div_in    = {1'b0, c_mlen} + 17'(PACKET_BYTES - 1);
        c_div_prod  = PROD_W'(c_div_in) * PROD_W'(C_RECIP);

        n_bytes_left   = c_first_msg ? c_mlen : r_bytes_left;
        n_packet_total = c_first_msg ? c_div_prod[DIV_S +: 16] : r_packet_total;
        n_id_latch     = c_first_msg ? i_packet_id : r_id_latch;
        c_pos          = c_first_msg ? 8'd0 : r_packet_pos;
        c_seq          = c_first_msg ? 16'd0 : r_sequence;

        c_first_pkt  = (c_pos == 8'd0);
        n_packet_len = r_packet_len;
        if (c_first_pkt) begin
            n_packet_len = (n_bytes_left < C_PB16) ? n_bytes_left[7:0] : C_PB8;
        end
        n_data_sum = (c_first_pkt ? 16'd0 : r_data_sum) + 16'(i_data_byte);

        c_pos_inc  = c_pos + 8'd1;
        c_pkt_last = (c_pos_inc >= n_packet_len);

        // wrap to the next packet on its last data byte
        n_packet_pos = c_pkt_last ? 8'd0 : c_pos_inc;
        n_sequence   = c_pkt_last ? c_seq + 16'd1 : c_seq;
        n_bytes_left = n_bytes_left - 16'd1;
    end

    always_comb begin
        o_cmd.data_byte    = i_data_byte;
        o_cmd.data_index   = c_pos;
        o_cmd.pkt_last     = c_pkt_last;
        o_cmd.timestamp    = i_timestamp;
        o_cmd.packet_len   = n_packet_len;
        o_cmd.sequence_num = c_seq;
        o_cmd.packet_total = n_packet_total;
        o_cmd.packet_id    = n_id_latch;
        o_cmd.checksum     = n_data_sum;
    end

    assign o_source_id = r_source_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id    <= '0;
            r_bytes_left   <= '0;
            r_packet_pos   <= '0;
            r_sequence     <= '0;
            r_packet_total <= '0;
            r_packet_len   <= '0;
            r_id_latch     <= '0;
            r_data_sum     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_source_id <= i_cfg_data;
            end
            if (i_accept) begin
                r_bytes_left   <= n_bytes_left;
                r_packet_pos   <= n_packet_pos;
                r_sequence     <= n_sequence;
                r_packet_total <= n_packet_total;
                r_packet_len   <= n_packet_len;
                r_id_latch     <= n_id_latch;
                r_data_sum     <= n_data_sum;
            end
        end
    end

endmodule

// File: sv/mpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_back
// Word assembler: lays header, data, padding and trailer bytes of a packet
// into 8-byte words, one word position per cycle while a command waits and the result queue has room.
// ----------------------------------------------------------------------------
module mpf_back #(
    parameter int unsigned PACKET_BYTES = mpf_pkg::PACKET_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [63:0]   i_source_id,
    input  mpf_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    input  logic          i_out_full,
    output logic          o_out_push,
    output mpf_pkg::t_res o_out
);

    import mpf_pkg::*;

    // byte positions within one packet's stream
    localparam int unsigned POS_W = $clog2(HDR_BYTES + PACKET_BYTES + 6);
    localparam int unsigned EW    = POS_W + 1;

    localparam logic [EW-1:0] C_HDR     = EW'(HDR_BYTES);
    localparam logic [EW-1:0] C_TRL     = EW'(HDR_BYTES + PACKET_BYTES);
    localparam logic [EW-1:0] C_END     = EW'(HDR_BYTES + PACKET_BYTES + 5);
    localparam logic [5:0]    C_HDR_TOP = 6'(HDR_BYTES - 1);

    localparam logic [2:0] TRL_SUM_HI = 3'd0;
    localparam logic [2:0] TRL_SUM_LO = 3'd1;
    localparam logic [2:0] TRL_END_0  = 3'd2;
    localparam logic [2:0] TRL_END_1  = 3'd3;
    localparam logic [2:0] TRL_END_2  = 3'd4;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        r = (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h57 + 8'(nib);
        return r;
    endfunction

    logic [POS_W-1:0]         r_pos;
    logic [63:0]              r_word;
    logic [EW-1:0]            c_base, c_word_end, c_data_pos, c_end, c_next;
    logic                     c_done, c_emit, c_step;
    logic [8*HDR_BYTES-1:0]   c_hdr;
    logic [63:0]              c_word;
    logic [EW-1:0]            c_q   [8];
    logic [5:0]               c_hix [8];
    logic [2:0]               c_tix [8];
    logic [7:0]               c_b   [8];

    always_comb begin
        c_hdr = {32'hAAAA_AAAA, 8'h7E, 64'hDDDD_DDDD_DDDD_DDDD, i_source_id,
                 8'h00, 8'h00, i_cmd.timestamp, 8'h00, i_cmd.packet_len,
                 i_cmd.sequence_num, i_cmd.packet_total,
                 hex_char(i_cmd.packet_id[15:12]), hex_char(i_cmd.packet_id[11:8]),
                 hex_char(i_cmd.packet_id[7:4]), hex_char(i_cmd.packet_id[3:0]),
                 i_source_id, 8'h00};

        c_base     = EW'({r_pos[POS_W-1:3], 3'b000});
        c_word_end = c_base + EW'(8);
        c_data_pos = C_HDR + EW'(i_cmd.data_index);
        c_end      = i_cmd.pkt_last ? C_END : c_data_pos + EW'(1);
        c_next     = (c_word_end < c_end) ? c_word_end : c_end;
        c_done     = (c_next == c_end);
        c_emit     = (c_next == c_word_end) || (c_done && i_cmd.pkt_last);
        c_step     = i_cmd_valid && (!c_emit || !i_out_full);

        c_word = r_word;
        for (int j = 0; j < 8; j++) begin
            c_q[j]   = c_base + EW'(j);
            c_hix[j] = C_HDR_TOP - c_q[j][5:0];
            c_tix[j] = 3'(c_q[j] - C_TRL);
            if (c_q[j] < C_HDR) begin
                c_b[j] = c_hdr[{c_hix[j], 3'b000} +: 8];
            end else if (c_q[j] == c_data_pos) begin
                c_b[j] = i_cmd.data_byte;
            end else if (c_q[j] < C_TRL) begin
                c_b[j] = 8'h00;
            end else begin
                case (c_tix[j])
                    TRL_SUM_HI: c_b[j] = i_cmd.checksum[15:8];
                    TRL_SUM_LO: c_b[j] = i_cmd.checksum[7:0];
                    TRL_END_0:  c_b[j] = 8'h1C;
                    TRL_END_1:  c_b[j] = 8'h71;
                    TRL_END_2:  c_b[j] = 8'hC7;
                    default:    c_b[j] = 8'h00;
                endcase
            end
            if ((c_q[j] >= EW'(r_pos)) && (c_q[j] < c_end)) begin
                c_word[63-8*j -: 8] = c_b[j];
            end
        end
    end

    always_comb begin
        o_out.frame_word = c_word;
        o_out.byte_count = 4'(c_next - c_base);
        o_out.packet_end = c_done && i_cmd.pkt_last;
        // last unless a later word of this item still fills or flushes
        o_out.last       = c_done || (!i_cmd.pkt_last && (c_end < c_base + EW'(16)));
    end

    assign o_out_push = c_step && c_emit;
    assign o_cmd_pop  = c_step && c_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_word <= '0;
        end else if (c_step) begin
            r_pos  <= (c_done && i_cmd.pkt_last) ? '0 : c_next[POS_W-1:0];
            r_word <= c_emit ? 64'd0 : c_word;
        end
    end

endmodule

// File: sv/message_packet_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_packet_framer_unit
// Splits message bytes into framed packets, packed into 8-byte words.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  config    | i_cfg_we            | i_cfg_data (source id)
//  input     | push / full         | i_data_byte, i_message_length,
//            |                     | i_packet_id, i_timestamp
//  result    | pop / empty         | o_frame_word, o_byte_count,
//            |                     | o_packet_end, o_last
//
//  Each data item fills its byte of the current word; a packet's first item also
//  lays out the header words before its partial word, and its last item the words
//  of padding and trailer. The back-end assembler, one word position per cycle
//  unless stalled, sets the pace; a command queue lets the input keep flowing meanwhile.
//  Reset is synchronous, active low, and needs no clearing pass.
//  A full result queue stalls the assembler; a full command queue raises full.
// ----------------------------------------------------------------------------
module message_packet_framer_unit #(
    parameter int unsigned PACKET_BYTES = mpf_pkg::PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_message_length,
    input  logic [15:0] i_packet_id,
    input  logic [31:0] i_timestamp,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_frame_word,
    output logic [3:0]  o_byte_count,
    output logic        o_packet_end,
    output logic        o_last
);

    import mpf_pkg::*;

    logic        c_accept;
    t_cmd        w_cmd_in, w_cmd_head;
    t_res        w_res_in, w_res_head;
    logic [63:0] w_source_id;
    logic        w_cmd_empty, w_cmd_pop;
    logic        w_out_full, w_out_push;

    assign c_accept = push && !full;

    mpf_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (c_accept),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_packet_id      (i_packet_id),
        .i_timestamp      (i_timestamp),
        .o_cmd            (w_cmd_in),
        .o_source_id      (w_source_id)
    );

    mpf_fifo #(
        .WIDTH (($bits(t_cmd))),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (c_accept),
        .i_wr_data (w_cmd_in),
        .o_full    (full),
        .i_rd_en   (w_cmd_pop),
        .o_rd_data (w_cmd_head),
        .o_empty   (w_cmd_empty)
    );

    mpf_back #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_source_id (w_source_id),
        .i_cmd       (w_cmd_head),
        .i_cmd_valid (!w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out       (w_res_in)
    );

    mpf_fifo #(
        .WIDTH (($bits(t_res))),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_out_push),
        .i_wr_data (w_res_in),
        .o_full    (w_out_full),
        .i_rd_en   (pop),
        .o_rd_data (w_res_head),
        .o_empty   (empty)
    );

    assign o_frame_word = w_res_head.frame_word;
    assign o_byte_count = w_res_head.byte_count;
    assign o_packet_end = w_res_head.packet_end;
    assign o_last       = w_res_head.last;

endmodule

// File: bench/tb_message_packet_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_packet_framer_unit
// Drives message bytes into the framer in random bursts and pops framed words
// under a rotating stall pattern. A local packet model predicts every word,
// and the monitor checks each popped word against the oldest prediction.
// The source id is rewritten between phases while the framer is idle.
// ----------------------------------------------------------------------------
module tb_message_packet_framer_unit;

    localparam int unsigned PKT_BYTES     = mpf_pkg::PACKET_BYTES_DEF;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    localparam logic [31:0] SYNC_PAT    = 32'hAAAA_AAAA;
    localparam logic [7:0]  START_DELIM = 8'h7E;
    localparam logic [63:0] CLK_SYNC    = 64'hDDDD_DDDD_DDDD_DDDD;
    localparam logic [7:0]  PAD_BYTE    = 8'h00;
    localparam logic [7:0]  TYPE_DATA   = 8'h00;
    localparam logic [23:0] END_PAT     = 24'h1C_71_C7;

    typedef struct {
        logic [7:0]  data;
        logic [15:0] mlen;
        logic [15:0] pid;
        logic [31:0] ts;
    } t_msg_byte;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [63:0] i_cfg_data       = '0;
    logic        push             = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte      = '0;
    logic [15:0] i_message_length = '0;
    logic [15:0] i_packet_id      = '0;
    logic [31:0] i_timestamp      = '0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [63:0] o_frame_word;
    logic [3:0]  o_byte_count;
    logic        o_packet_end;
    logic        o_last;

    message_packet_framer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_packet_id      (i_packet_id),
        .i_timestamp      (i_timestamp),
        .empty            (empty),
        .pop              (pop),
        .o_frame_word     (o_frame_word),
        .o_byte_count     (o_byte_count),
        .o_packet_end     (o_packet_end),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    // framer model state
    logic [63:0] src_id_model = '0;
    logic [15:0] msg_left     = '0;
    logic [7:0]  pkt_pos      = '0;
    logic [15:0] seq_num      = '0;
    logic [15:0] pkt_total    = '0;
    logic [7:0]  pkt_len      = '0;
    logic [15:0] id_hold      = '0;
    logic [15:0] sum_acc      = '0;
    logic [63:0] stage_buf    = '0;
    logic [3:0]  stage_cnt    = '0;

    // the newest word of an item is held back until its flags are final
    mpf_pkg::t_res held_word;
    logic          held_ok = 1'b0;

    mpf_pkg::t_res words_due[$];
    t_msg_byte     tx_bytes[$];

    int unsigned fail_count  = 0;
    int unsigned items_taken = 0;
    int unsigned words_seen  = 0;
    int unsigned msg_count   = 0;
    int unsigned cfg_writes  = 0;
    int unsigned cycle_count = 0;
    logic        item_taken  = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned rx_left    = 0;
    logic [15:0] rx_pat     = '1;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib - 4'd10);
    endfunction

    task automatic close_word(input logic end_flag);
        mpf_pkg::t_res w;
        w.frame_word = stage_buf << (8 * (8 - stage_cnt));
        w.byte_count = stage_cnt;
        w.packet_end = end_flag;
        w.last       = 1'b0;
        if (held_ok)
            words_due = {words_due, held_word};
        held_word = w;
        held_ok   = 1'b1;
        stage_buf = '0;
        stage_cnt = '0;
    endtask

    task automatic stage_byte(input logic [7:0] b);
        stage_buf = {stage_buf[55:0], b};
        stage_cnt = stage_cnt + 4'd1;
        if (stage_cnt >= 4'd8)
            close_word(1'b0);
    endtask

    task automatic stage_be(input logic [63:0] v, input int unsigned nbytes);
        int unsigned i;
        for (i = nbytes; i > 0; i--)
            stage_byte(8'(v >> (8 * (i - 1))));
    endtask

    task automatic frame_item(input logic [7:0] db, input logic [15:0] mlen_in,
                              input logic [15:0] pid, input logic [31:0] ts);
        logic [15:0] mlen;
        int unsigned i;
        mlen = mlen_in;
        if (msg_left == 16'd0) begin
            // zero length counts as a one-byte message
            if (mlen == 16'd0)
                mlen = 16'd1;
            msg_left  = mlen;
            seq_num   = '0;
            pkt_total = 16'((32'(mlen) + PKT_BYTES - 1) / PKT_BYTES);
            id_hold   = pid;
            pkt_pos   = '0;
        end
        if (pkt_pos == 8'd0) begin
            pkt_len = (msg_left < PKT_BYTES) ? msg_left[7:0] : 8'(PKT_BYTES);
            sum_acc = '0;
            stage_be(SYNC_PAT, 4);
            stage_byte(START_DELIM);
            stage_be(CLK_SYNC, 8);
            stage_be(src_id_model, 8);
            stage_byte(PAD_BYTE);
            stage_byte(TYPE_DATA);
            stage_be(ts, 4);
            stage_be(pkt_len, 2);
            stage_be(seq_num, 2);
            stage_be(pkt_total, 2);
            stage_byte(hex_ascii(id_hold[15:12]));
            stage_byte(hex_ascii(id_hold[11:8]));
            stage_byte(hex_ascii(id_hold[7:4]));
            stage_byte(hex_ascii(id_hold[3:0]));
            stage_be(src_id_model, 8);
            stage_byte(PAD_BYTE);
        end
        stage_byte(db);
        sum_acc  = sum_acc + 16'(db);
        pkt_pos  = pkt_pos + 8'd1;
        msg_left = msg_left - 16'd1;
        if (pkt_pos >= pkt_len) begin
            for (i = pkt_len; i < PKT_BYTES; i++)
                stage_byte(PAD_BYTE);
            stage_be(sum_acc, 2);
            stage_be(END_PAT, 3);
            // a word filled by the last trailer byte takes the packet end flag
            if (stage_cnt > 4'd0)
                close_word(1'b1);
            else if (held_ok)
                held_word.packet_end = 1'b1;
            pkt_pos = '0;
            seq_num = seq_num + 16'd1;
        end
        if (held_ok) begin
            held_word.last = 1'b1;
            words_due = {words_due, held_word};
            held_ok = 1'b0;
        end
    endtask

    // queue one message; bytes after the first carry junk length and id
    task automatic add_message(input logic [15:0] mlen, input int unsigned n_bytes,
                               input logic [15:0] pid, input logic fixed,
                               input logic [7:0] dval, input logic [31:0] tval);
        t_msg_byte   mb;
        int unsigned i;
        for (i = 0; i < n_bytes; i++) begin
            mb.data = fixed ? dval : 8'($urandom);
            mb.ts   = fixed ? tval : $urandom;
            mb.mlen = (i == 0) ? mlen : 16'($urandom);
            mb.pid  = (i == 0) ? pid : 16'($urandom);
            tx_bytes = {tx_bytes, mb};
        end
        msg_count++;
    endtask

    task automatic set_source_id(input logic [63:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        src_id_model = v;
        cfg_writes++;
    endtask

    task automatic drain();
        do
            @(posedge i_clk);
        while (tx_bytes.size() != 0 || push || words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin : driver
        t_msg_byte mb;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || item_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
            if (burst_left > 0 && tx_bytes.size() != 0) begin
                mb = tx_bytes.pop_front();
                push             <= 1'b1;
                i_data_byte      <= mb.data;
                i_message_length <= mb.mlen;
                i_packet_id      <= mb.pid;
                i_timestamp      <= mb.ts;
                burst_left--;
            end else begin
                push <= 1'b0;
                if (burst_left == 0)
                    gap_left--;
            end
        end
    end

    // receiver: rotate a stall pattern, reloaded at random whenever rx_left runs out
    always @(negedge i_clk) begin : receiver
        if (rx_left == 0) begin
            rx_left = 32;
            case ($urandom_range(0, 3))
                0: begin
                    rx_pat = '1;
                end
                1: begin
                    rx_pat = 16'($urandom);
                end
                2: begin
                    rx_pat = 16'h0001;
                end
                default: begin
                    rx_pat = 16'hF0F0;
                end
            endcase
        end
        pop    <= rx_pat[0];
        rx_pat  = {rx_pat[0], rx_pat[15:1]};
        rx_left--;
    end

    always @(posedge i_clk) begin : monitor
        mpf_pkg::t_res want;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            // check before predicting: a word never comes from this edge's item
            if (pop && !empty) begin
                words_seen++;
                if (words_due.size() == 0) begin
                    $error("unexpected word: frame_word %h byte_count %0d",
                           o_frame_word, o_byte_count);
                    fail_count++;
                end else begin
                    want = words_due.pop_front();
                    if (o_frame_word !== want.frame_word) begin
                        $error("frame_word: expected %h, got %h",
                               want.frame_word, o_frame_word);
                        fail_count++;
                    end
                    if (o_byte_count !== want.byte_count) begin
                        $error("byte_count: expected %0d, got %0d",
                               want.byte_count, o_byte_count);
                        fail_count++;
                    end
                    if (o_packet_end !== want.packet_end) begin
                        $error("packet_end: expected %b, got %b",
                               want.packet_end, o_packet_end);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (push && !full) begin
                items_taken++;
                frame_item(i_data_byte, i_message_length, i_packet_id, i_timestamp);
            end
            item_taken <= push && !full;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned len;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero length, hex digit range, junk mid-message
        set_source_id(64'h0);
        add_message(16'd1, 1, 16'h0000, 1'b1, 8'h00, 32'h0000_0000);
        add_message(16'd1, 1, 16'hFFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF);
        add_message(16'd0, 1, 16'h09AF, 1'b0, 8'h00, 32'h0);
        add_message(16'd3, 3, 16'h5A3C, 1'b0, 8'h00, 32'h0);
        add_message(16'd2, 2, 16'($urandom), 1'b0, 8'h00, 32'h0);
        drain();

        // one full packet followed by a one-byte packet
        set_source_id('1);
        add_message(16'd201, 201, 16'($urandom), 1'b0, 8'h00, 32'h0);
        drain();

        repeat (5) begin
            set_source_id({$urandom, $urandom});
            n = 0;
            while (n < 16) begin
                if ($urandom_range(0, 15) == 0) begin
                    add_message(16'd0, 1, 16'($urandom), 1'b0, 8'h00, 32'h0);
                    n++;
                end else begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    add_message(16'(len), len, 16'($urandom), 1'b0, 8'h00, 32'h0);
                    n += len;
                end
            end
            drain();
        end

        // open a very long message and leave it unfinished
        set_source_id(64'h8000_0000_0000_0001);
        add_message(16'($urandom_range(32768, 65535)), 12, 16'($urandom),
                    1'b0, 8'h00, 32'h0);
        drain();

        $display("Covered %0d input items in %0d messages, %0d framed words checked,",
                 items_taken, msg_count, words_seen);
        $display("under %0d source id settings, with sender gaps and receiver stalls.",
                 cfg_writes);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
